// ===== src/z85_pkg.sv =====
package z85_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    localparam logic [7:0] CHAR_BASE = 8'd32;

    // digit per printable byte, indexed by byte - 0x20
    localparam logic [7:0] DIGIT_TABLE [96] = '{
        8'h00, 8'h44, 8'h00, 8'h54, 8'h53, 8'h52, 8'h48, 8'h00,
        8'h4B, 8'h4C, 8'h46, 8'h41, 8'h00, 8'h3F, 8'h3E, 8'h45,
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h40, 8'h00, 8'h49, 8'h42, 8'h4A, 8'h47,
        8'h51, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
        8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
        8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A,
        8'h3B, 8'h3C, 8'h3D, 8'h4D, 8'h00, 8'h4E, 8'h43, 8'h00,
        8'h00, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10,
        8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
        8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20,
        8'h21, 8'h22, 8'h23, 8'h4F, 8'h00, 8'h50, 8'h00, 8'h00
    };

    // one queue entry: a finished group or an error marker
    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        msg_end;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [6:0] decode_digit(input logic [7:0] ch);
        logic [7:0] idx;
        begin
            idx = ch - CHAR_BASE;
            decode_digit = DIGIT_TABLE[idx[6:0]][6:0];
        end
    endfunction

endpackage

// ===== src/z85_front.sv =====
module z85_front
    import z85_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   in_char,
    input  logic         msg_last,
    input  logic         q_full,
    output logic         q_push,
    output entry_t       q_entry
);

    logic [31:0] group_reg, group_next;
    logic [2:0]  count_reg, count_next;
    logic        skip_reg, skip_next;
    logic        take;
    logic        bad_char;
    logic [31:0] acc;

    assign in_ready = !q_full;
    assign take     = in_valid && !q_full;
    // only 0x20..0x7F are decodable
    assign bad_char = in_char[7] || (in_char[7:5] == 3'b000);
    assign acc      = 32'(group_reg * 32'd85) + {25'd0, decode_digit(in_char)};

    always_comb
    begin
        group_next = group_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        q_push     = 1'b0;
        q_entry    = '{value: acc, status: ST_OK, msg_end: msg_last};
        if (take)
        begin
            if (skip_reg)
            begin
                if (msg_last)
                begin
                    skip_next  = 1'b0;
                    group_next = '0;
                    count_next = '0;
                end
            end
            else if (bad_char)
            begin
                q_push         = 1'b1;
                q_entry.status = ST_BAD;
                skip_next      = !msg_last;
                group_next     = '0;
                count_next     = '0;
            end
            else if (count_reg == 3'd4)
            begin
                q_push     = 1'b1;
                group_next = '0;
                count_next = '0;
            end
            else if (msg_last)
            begin
                q_push         = 1'b1;
                q_entry.status = ST_LEN;
                group_next     = '0;
                count_next     = '0;
            end
            else
            begin
                group_next = acc;
                count_next = count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            count_reg <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            group_reg <= group_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ===== src/z85_fifo.sv =====
module z85_fifo
    import z85_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/z85_back.sv =====
module z85_back
    import z85_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  entry_t      head_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [1:0]  status,
    output logic        run_end,
    output logic        msg_end
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] status_reg, status_next;
    logic       run_end_reg, run_end_next;
    logic       msg_end_reg, msg_end_next;
    logic       load;
    logic       is_err;
    logic [7:0] sel_byte;

    assign load   = head_valid && (!valid_reg || out_ready);
    assign is_err = (head_data.status != ST_OK);

    // most significant byte of the group goes out first
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head_data.value[31:24];
            2'd1:    sel_byte = head_data.value[23:16];
            2'd2:    sel_byte = head_data.value[15:8];
            default: sel_byte = head_data.value[7:0];
        endcase
    end

    always_comb
    begin
        idx_next     = idx_reg;
        valid_next   = valid_reg && !out_ready;
        byte_next    = byte_reg;
        status_next  = status_reg;
        run_end_next = run_end_reg;
        msg_end_next = msg_end_reg;
        pop          = 1'b0;
        if (load)
        begin
            valid_next  = 1'b1;
            status_next = head_data.status;
            if (is_err)
            begin
                byte_next    = '0;
                run_end_next = 1'b1;
                msg_end_next = head_data.msg_end;
                pop          = 1'b1;
            end
            else
            begin
                byte_next    = sel_byte;
                run_end_next = (idx_reg == 2'd3);
                msg_end_next = (idx_reg == 2'd3) && head_data.msg_end;
                pop          = (idx_reg == 2'd3);
                idx_next     = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        status_reg  <= status_next;
        run_end_reg <= run_end_next;
        msg_end_reg <= msg_end_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign status    = status_reg;
    assign run_end   = run_end_reg;
    assign msg_end   = msg_end_reg;

endmodule

// ===== src/z85_stream_decoder.sv =====
// Path: beats caused by an accepted character pass the result queue, then the output register.
// Throughput: one character per cycle on the slave side; one beat per cycle on the master
// side while m_tready is high and the queue is not empty. A complete group of five characters
// yields four beats; the result queue between front and back (QUEUE_DEPTH entries) drops
// s_tready only while it is full. Reset: rst_n is asynchronous and active low; it clears
// the partial group, skip flag, queue and output valid flag.
module z85_stream_decoder
    import z85_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // msg_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_end, [15:9] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // msg_end
);

    entry_t     push_data;
    entry_t     head_data;
    logic       push, full, pop, head_valid;
    logic [7:0] out_byte;
    logic       run_end;

    z85_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .msg_last (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_entry  (push_data)
    );

    z85_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    z85_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .status     (m_tuser),
        .run_end    (run_end),
        .msg_end    (m_tlast)
    );

    assign m_tdata = {7'd0, run_end, out_byte};

endmodule

// ===== src/z85_checker.sv =====
module z85_checker
    import z85_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BAD || m_tuser == ST_LEN))
        else $error("unknown status code");

    // error beats are single, zero-valued and close their run
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[7:0] == 8'd0 && m_tdata[8])
        else $error("malformed error beat");

    a_len_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_LEN |-> m_tlast)
        else $error("length error without message end");

    a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[8] && m_tdata[15:9] == 7'd0)
        else $error("message end off a run boundary");

endmodule

bind z85_stream_decoder z85_checker u_z85_checker (.*);

// ===== sim/z85_stream_decoder_tb.sv =====
module z85_stream_decoder_tb
    import z85_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES  = 10;

    localparam string ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       run_end;
        logic       msg_end;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // decoder state as predicted
    logic [31:0] grp_acc = '0;
    int          grp_len = 0;
    bit          skip_rest = 1'b0;

    beat_t       pending_beats[$];
    int          mismatches = 0;
    int          beats_seen = 0;
    int          chars_sent = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          stall_req = 1'b0;
    int          stall_left = 0;
    int          rx_gap = 0;

    z85_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [6:0] digit_value(input logic [7:0] ch);
        for (int i = 0; i < 85; i++)
        begin
            if (ALPHABET[i] == ch)
                return 7'(i);
        end
        return 7'd0;
    endfunction

    function automatic logic [7:0] pick_text();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(32, 127));
        return ALPHABET[$urandom_range(0, 84)];
    endfunction

    function automatic logic [7:0] pick_bad();
        int r;
        r = $urandom_range(0, 159);
        return (r < 32) ? 8'(r) : 8'(r + 96);
    endfunction

    task automatic predict_decode(input logic [7:0] ch, input logic last);
        beat_t       b;
        logic [31:0] v;
        if (skip_rest)
        begin
            if (last)
            begin
                skip_rest = 1'b0;
                grp_acc = '0;
                grp_len = 0;
            end
            return;
        end
        if (ch < 8'd32 || ch >= 8'd128)
        begin
            b = '{data: 8'h00, status: ST_BAD, run_end: 1'b1, msg_end: last};
            pending_beats = {pending_beats, b};
            grp_acc = '0;
            grp_len = 0;
            skip_rest = !last;
            return;
        end
        grp_acc = grp_acc * 32'd85 + 32'(digit_value(ch));
        grp_len++;
        if (grp_len == 5)
        begin
            for (int k = 0; k < 4; k++)
            begin
                v = grp_acc >> (24 - 8 * k);
                b = '{data: v[7:0], status: ST_OK, run_end: (k == 3),
                      msg_end: (k == 3) && last};
                pending_beats = {pending_beats, b};
            end
            grp_acc = '0;
            grp_len = 0;
        end
        else if (last)
        begin
            b = '{data: 8'h00, status: ST_LEN, run_end: 1'b1, msg_end: 1'b1};
            pending_beats = {pending_beats, b};
            grp_acc = '0;
            grp_len = 0;
        end
    endtask

    // called at a rising edge; returns at the edge where the beat was taken, valid still high
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_decode(ch, last);
        chars_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    // bad_at < 0: no bad character
    task automatic send_message(input int n, input int bad_at);
        for (int i = 0; i < n; i++)
            send_char((i == bad_at) ? pick_bad() : pick_text(), i == n - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR beat %0d %s: got %0h, want %0h", beats_seen, what, got, want);
        mismatches++;
    endtask

    // receiver: random ready, with a long hold-off on request
    always @(posedge clk)
    begin
        if (stall_req)
        begin
            stall_left = STALL_CYCLES;
            stall_req = 1'b0;
        end
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                rx_gap = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
                report_mismatch("unexpected beat, byte", int'(m_tdata[7:0]), 0);
            else
            begin
                want = pending_beats.pop_front();
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("out_byte", int'(m_tdata[7:0]), int'(want.data));
                if (m_tuser !== want.status)
                    report_mismatch("status", int'(m_tuser), int'(want.status));
                if (m_tdata[8] !== want.run_end)
                    report_mismatch("run_end", int'(m_tdata[8]), int'(want.run_end));
                if (m_tlast !== want.msg_end)
                    report_mismatch("msg_end", int'(m_tlast), int'(want.msg_end));
            end
            beats_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("z85_stream_decoder: mismatch");
                $finish;
            end
        end
    end

    task automatic test_known_groups();
        send_text("HelloWorld");
        // 85^5 - 1 wraps past 2^32
        send_text("#####");
    endtask

    task automatic test_special_chars();
        // lowest printable and 0x7F both decode as zero; short message
        send_char(8'h20, 1'b0);
        send_char(8'h7F, 1'b1);
        // bad character mid-message, rest dropped up to the last flag
        send_char(8'h00, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h41, 1'b1);
        // bad character that is also the last one
        send_char(8'h80, 1'b1);
        send_char(8'h1F, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        stall_req = 1'b1;
        for (int i = 0; i < 4; i++)
            send_message(10, -1);
        idle_on = 1'b1;
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        for (int i = 0; i < 4; i++)
            send_message(15, -1);
        idle_on = 1'b1;
    endtask

    task automatic test_random_messages();
        int stop_at;
        stop_at = chars_sent + 150;
        while (chars_sent < stop_at)
            send_message(5 * $urandom_range(1, 4), -1);
    endtask

    task automatic test_broken_messages();
        int stop_at;
        int n;
        stop_at = chars_sent + 80;
        while (chars_sent < stop_at)
        begin
            n = $urandom_range(1, 19);
            if ($urandom_range(0, 1) == 0)
                send_message(n, $urandom_range(0, n - 1));
            else
                send_message((n % 5 == 0) ? n + 1 : n, -1);
        end
    endtask

    task automatic test_noise();
        for (int i = 0; i < 60; i++)
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_known_groups();
        test_special_chars();
        wait_drained();
        test_output_backpressure();
        wait_drained();
        test_full_rate();
        test_random_messages();
        wait_drained();
        test_broken_messages();
        test_noise();
        // close any message the noise left open
        send_char(8'h30, 1'b1);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("z85_stream_decoder: match");
        else
            $display("z85_stream_decoder: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/z85_pkg.sv
src/z85_front.sv
src/z85_fifo.sv
src/z85_back.sv
src/z85_stream_decoder.sv
src/z85_checker.sv
sim/z85_stream_decoder_tb.sv
